// ----- hdl/actx_pkg.sv -----
// Shared types, constants and AES helper functions for the AES-128 CTR keystream block.
`default_nettype none
package actx_pkg;

    localparam int BlockBytes = 16;
    localparam int PosWidth   = 4;
    localparam int QueueDepth = 2;

    localparam logic [1:0] CfgKeyHigh   = 2'd0;
    localparam logic [1:0] CfgKeyLow    = 2'd1;
    localparam logic [1:0] CfgNonceHigh = 2'd2;
    localparam logic [1:0] CfgNonceLow  = 2'd3;

    // One queue entry: a classified byte.
    typedef struct packed {
        logic [7:0]          data;
        logic                new_block;
        logic [PosWidth-1:0] pos;
        logic                restart;
    } entry_t;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [7:0] xtime(input logic [7:0] a);
        xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    // Byte i of a 128-bit block sits at bits [127-8i -: 8].
    function automatic logic [127:0] sub_shift(input logic [127:0] s);
        logic [127:0] r;
        r = '0;
        for (int c = 0; c < 4; c++) begin
            for (int j = 0; j < 4; j++) begin
                r[127 - 8 * (j + 4 * c) -: 8] = SBOX[s[127 - 8 * (j + 4 * ((c + j) % 4)) -: 8]];
            end
        end
        sub_shift = r;
    endfunction

    function automatic logic [127:0] mix_columns(input logic [127:0] t);
        logic [127:0] r;
        logic [7:0]   a0, a1, a2, a3;
        r = '0;
        for (int c = 0; c < 4; c++) begin
            a0 = t[127 - 32 * c -: 8];
            a1 = t[119 - 32 * c -: 8];
            a2 = t[111 - 32 * c -: 8];
            a3 = t[103 - 32 * c -: 8];
            r[127 - 32 * c -: 8] = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
            r[119 - 32 * c -: 8] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
            r[111 - 32 * c -: 8] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
            r[103 - 32 * c -: 8] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
        end
        mix_columns = r;
    endfunction

    function automatic logic [127:0] next_round_key(input logic [127:0] k,
                                                    input logic [7:0] rcon);
        logic [31:0] w, w0, w1, w2, w3;
        w  = {SBOX[k[23:16]] ^ rcon, SBOX[k[15:8]], SBOX[k[7:0]], SBOX[k[31:24]]};
        w0 = k[127:96] ^ w;
        w1 = k[95:64] ^ w0;
        w2 = k[63:32] ^ w1;
        w3 = k[31:0] ^ w2;
        next_round_key = {w0, w1, w2, w3};
    endfunction

endpackage
`default_nettype wire

// ----- hdl/aes128_ctr_keystream_xor.sv -----
// Top level of the AES-128 counter-mode keystream XOR block.
// Usage: bytes arrive on the input channel (in_valid, in_stall, data_byte,
// restart), one per beat, and leave on the output channel (out_valid,
// out_stall, out_byte) in the same order, one result beat per input beat.
// The key and the initial counter are written through cfg_we, cfg_index and
// cfg_data while the block is idle; index 0 and 1 hold the key, 2 and 3 the
// nonce. A beat with restart set reloads the counter from the nonce.
// Throughput: one byte per cycle inside a 16-byte block while the output
// is not stalled. The first byte of each block waits for the iterative
// round core, which works through one load step and ten rounds per block.
// A two-entry queue between front end and cipher lets the input take beats,
// until it fills, while the output register holds a stalled result.
// Reset clears the counter, the byte position and all valid flags.
`default_nettype none
module aes128_ctr_keystream_xor (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [63:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  data_byte,
    input  wire logic        restart,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [7:0]       out_byte
);
    import actx_pkg::*;

    logic [63:0] key_high_reg, key_low_reg, nonce_high_reg, nonce_low_reg;
    logic        q_push, q_full, q_pop, q_nempty;
    entry_t      q_in, q_head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_high_reg   <= '0;
            key_low_reg    <= '0;
            nonce_high_reg <= '0;
            nonce_low_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CfgKeyHigh:   key_high_reg   <= cfg_data;
                CfgKeyLow:    key_low_reg    <= cfg_data;
                CfgNonceHigh: nonce_high_reg <= cfg_data;
                CfgNonceLow:  nonce_low_reg  <= cfg_data;
                default:      ;
            endcase
        end
    end

    actx_front u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .data_byte(data_byte), .restart(restart), .q_push(q_push),
        .q_entry(q_in), .q_full(q_full)
    );

    actx_queue u_queue (
        .clk(clk), .rst_n(rst_n), .push(q_push), .push_entry(q_in), .full(q_full),
        .pop(q_pop), .not_empty(q_nempty), .head(q_head)
    );

    actx_back u_back (
        .clk(clk), .rst_n(rst_n), .key({key_high_reg, key_low_reg}),
        .nonce({nonce_high_reg, nonce_low_reg}), .q_valid(q_nempty),
        .q_head(q_head), .q_pop(q_pop), .out_valid(out_valid),
        .out_stall(out_stall), .out_byte(out_byte)
    );

`ifndef SYNTHESIS
    // The queue never pops when empty.
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_nempty) else $error("pop from empty queue");
    // The input is stalled only while the queue is full.
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> q_full) else $error("input stalled with room in queue");
    // A popped beat produces an output beat on the next cycle.
    a_pop_out: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> out_valid) else $error("popped beat lost");
`endif
endmodule
`default_nettype wire

// ----- hdl/actx_front.sv -----
// Front end: byte position tracking and classification of each beat into the queue.
`default_nettype none
module actx_front (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_stall,
    input  wire logic [7:0]      data_byte,
    input  wire logic            restart,
    output logic                 q_push,
    output actx_pkg::entry_t     q_entry,
    input  wire logic            q_full
);
    import actx_pkg::*;

    logic [PosWidth-1:0] pos_reg, pos_next;
    logic [PosWidth-1:0] cur_pos;

    assign in_stall = q_full;
    assign q_push   = in_valid && !q_full;
    assign cur_pos  = restart ? '0 : pos_reg;

    always_comb
    begin
        q_entry.data      = data_byte;
        q_entry.pos       = cur_pos;
        q_entry.restart   = restart;
        q_entry.new_block = (cur_pos == '0);
        pos_next          = q_push ? cur_pos + PosWidth'(1) : pos_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
        end
    end
endmodule
`default_nettype wire

// ----- hdl/actx_queue.sv -----
// Short FIFO between the classifying front end and the cipher back end.
`default_nettype none
module actx_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  actx_pkg::entry_t     push_entry,
    output logic                 full,
    input  wire logic            pop,
    output logic                 not_empty,
    output actx_pkg::entry_t     head
);
    import actx_pkg::*;

    localparam int AW = $clog2(QueueDepth);

    entry_t          mem_reg [QueueDepth];
    logic [AW-1:0]   wp_reg, rp_reg;
    logic [AW:0]     cnt_reg;

    assign full      = (cnt_reg == (AW+1)'(QueueDepth));
    assign not_empty = (cnt_reg != '0);
    assign head      = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= wp_reg + AW'(1);
            end
            if (pop)
            begin
                rp_reg <= rp_reg + AW'(1);
            end
            cnt_reg <= cnt_reg + {{AW{1'b0}}, push} - {{AW{1'b0}}, pop};
        end
    end
endmodule
`default_nettype wire

// ----- hdl/actx_back.sv -----
// Back end: counter, iterative AES-128 round core, keystream buffer and output register.
`default_nettype none
module actx_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic [127:0]    key,
    input  wire logic [127:0]    nonce,
    input  wire logic            q_valid,
    input  actx_pkg::entry_t     q_head,
    output logic                 q_pop,
    output logic                 out_valid,
    input  wire logic            out_stall,
    output logic [7:0]           out_byte
);
    import actx_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } aes_state_t;

    aes_state_t     st_reg;
    logic [127:0]   ctr_reg;
    logic [127:0]   s_reg, rk_reg, ks_reg;
    logic [7:0]     rcon_reg;
    logic [3:0]     round_reg;
    logic           ks_ok_reg;
    logic           oval_reg;
    logic [7:0]     obyte_reg;

    logic           out_free, need_block, can_use, start;
    logic [127:0]   ctr_base, rk_new, sr;

    assign out_free   = !oval_reg || !out_stall;
    assign need_block = q_head.new_block;
    // A new-block beat waits for the core; other beats use the stored keystream.
    assign can_use    = q_valid && out_free && !need_block;
    assign start      = q_valid && need_block && st_reg == ST_IDLE;
    assign q_pop      = can_use || (q_valid && out_free && need_block && ks_ok_reg);
    assign ctr_base   = q_head.restart ? nonce : ctr_reg;
    assign rk_new     = next_round_key(rk_reg, rcon_reg);
    assign sr         = sub_shift(s_reg);
    assign out_valid  = oval_reg;
    assign out_byte   = obyte_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg    <= ST_IDLE;
            ctr_reg   <= '0;
            ks_ok_reg <= 1'b0;
            oval_reg  <= 1'b0;
            round_reg <= '0;
            rcon_reg  <= 8'h01;
        end
        else
        begin
            if (out_free)
            begin
                oval_reg <= q_pop;
            end
            if (q_pop && need_block)
            begin
                ks_ok_reg <= 1'b0;
            end
            case (st_reg)
                ST_IDLE:
                begin
                    if (start && !ks_ok_reg)
                    begin
                        st_reg    <= ST_RUN;
                        round_reg <= 4'd1;
                        rcon_reg  <= 8'h01;
                        ctr_reg   <= ctr_base + 128'd1;
                    end
                end
                ST_RUN:
                begin
                    rcon_reg  <= xtime(rcon_reg);
                    round_reg <= round_reg + 4'd1;
                    if (round_reg == 4'd10)
                    begin
                        st_reg    <= ST_IDLE;
                        ks_ok_reg <= 1'b1;
                    end
                end
                default:
                begin
                    st_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (st_reg == ST_IDLE && start && !ks_ok_reg)
        begin
            s_reg  <= ctr_base ^ key;
            rk_reg <= key;
        end
        else if (st_reg == ST_RUN)
        begin
            rk_reg <= rk_new;
            if (round_reg == 4'd10)
            begin
                ks_reg <= sr ^ rk_new;
            end
            else
            begin
                s_reg <= mix_columns(sr) ^ rk_new;
            end
        end
        if (out_free && q_pop)
        begin
            obyte_reg <= q_head.data ^ ks_reg[127 - 8 * q_head.pos -: 8];
        end
    end
endmodule
`default_nettype wire

// ----- dv/aes128_ctr_keystream_xor_checker.sv -----
// Checker for the AES-128 CTR keystream block: predicts each output byte and compares it.
module aes128_ctr_keystream_xor_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        restart,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [7:0]  out_byte,
    output int          fails,
    output int          pending
);
    import actx_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic [63:0] key_hi, key_lo, nonce_hi, nonce_lo;
    logic [63:0] ctr_hi, ctr_lo;
    logic [3:0]  pos;
    logic [127:0] keystream;
    logic [7:0]  expected_bytes[$];

    function automatic logic [7:0] gf_double(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] gf_product(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] acc;
        acc = 8'h00;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) acc ^= a;
            a = gf_double(a);
        end
        return acc;
    endfunction

    function automatic logic [7:0] rot_left(input logic [7:0] x, input int n);
        return (x << n) | (x >> (8 - n));
    endfunction

    // The S-box as field inverse (x^254) followed by the affine map.
    function automatic logic [7:0] substitute(input logic [7:0] x);
        logic [7:0] inv, base;
        int e;
        inv = 8'h01;
        base = x;
        e = 254;
        while (e != 0) begin
            if (e % 2 == 1) inv = gf_product(inv, base);
            base = gf_product(base, base);
            e = e / 2;
        end
        return inv ^ rot_left(inv, 1) ^ rot_left(inv, 2) ^ rot_left(inv, 3)
               ^ rot_left(inv, 4) ^ 8'h63;
    endfunction

    function automatic logic [127:0] cipher_block(input logic [127:0] key,
                                                  input logic [127:0] blk);
        logic [7:0] rk[176];
        logic [7:0] s[16];
        logic [7:0] t[16];
        logic [7:0] w[4];
        logic [7:0] rc, f, a0, a1, a2, a3;
        logic [127:0] res;
        rc = 8'h01;
        for (int i = 0; i < 16; i++) rk[i] = key[127 - 8 * i -: 8];
        for (int i = 16; i < 176; i += 4) begin
            for (int j = 0; j < 4; j++) w[j] = rk[i - 4 + j];
            if (i % 16 == 0) begin
                f = w[0];
                w[0] = substitute(w[1]) ^ rc;
                w[1] = substitute(w[2]);
                w[2] = substitute(w[3]);
                w[3] = substitute(f);
                rc = gf_double(rc);
            end
            for (int j = 0; j < 4; j++) rk[i + j] = rk[i - 16 + j] ^ w[j];
        end
        for (int i = 0; i < 16; i++) s[i] = blk[127 - 8 * i -: 8] ^ rk[i];
        for (int r = 1; r <= 10; r++) begin
            for (int i = 0; i < 16; i++) s[i] = substitute(s[i]);
            for (int c = 0; c < 4; c++)
                for (int j = 0; j < 4; j++)
                    t[j + 4 * c] = s[j + 4 * ((c + j) % 4)];
            for (int c = 0; c < 4; c++) begin
                a0 = t[4 * c];
                a1 = t[4 * c + 1];
                a2 = t[4 * c + 2];
                a3 = t[4 * c + 3];
                if (r != 10) begin
                    s[4 * c]     = gf_double(a0) ^ gf_double(a1) ^ a1 ^ a2 ^ a3;
                    s[4 * c + 1] = a0 ^ gf_double(a1) ^ gf_double(a2) ^ a2 ^ a3;
                    s[4 * c + 2] = a0 ^ a1 ^ gf_double(a2) ^ gf_double(a3) ^ a3;
                    s[4 * c + 3] = gf_double(a0) ^ a0 ^ a1 ^ a2 ^ gf_double(a3);
                end else begin
                    s[4 * c]     = a0;
                    s[4 * c + 1] = a1;
                    s[4 * c + 2] = a2;
                    s[4 * c + 3] = a3;
                end
            end
            for (int i = 0; i < 16; i++) s[i] ^= rk[16 * r + i];
        end
        for (int i = 0; i < 16; i++) res[127 - 8 * i -: 8] = s[i];
        return res;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        logic [7:0] want;
        if (!rst_n) begin
            key_hi <= '0;
            key_lo <= '0;
            nonce_hi <= '0;
            nonce_lo <= '0;
            ctr_hi <= '0;
            ctr_lo <= '0;
            pos <= '0;
            keystream <= '0;
            expected_bytes.delete();
            fails <= 0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CfgKeyHigh:   key_hi <= cfg_data;
                    CfgKeyLow:    key_lo <= cfg_data;
                    CfgNonceHigh: nonce_hi <= cfg_data;
                    CfgNonceLow:  nonce_lo <= cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && !in_stall) begin
                logic [63:0] hi, lo;
                logic [3:0] p;
                logic [127:0] ks;
                hi = ctr_hi;
                lo = ctr_lo;
                p = pos;
                ks = keystream;
                if (restart) begin
                    hi = nonce_hi;
                    lo = nonce_lo;
                    p = '0;
                end
                if (p == 0) begin
                    ks = cipher_block({key_hi, key_lo}, {hi, lo});
                    lo = lo + 64'd1;
                    if (lo == 0) hi = hi + 64'd1;
                end
                expected_bytes.push_back(data_byte ^ ks[127 - 8 * p -: 8]);
                ctr_hi <= hi;
                ctr_lo <= lo;
                pos <= p + 4'd1;
                keystream <= ks;
            end
            if (out_valid && !out_stall) begin
                if (expected_bytes.size() == 0) begin
                    if (fails < 10) $display("unexpected output byte %02h", out_byte);
                    fails <= fails + 1;
                end else begin
                    want = expected_bytes.pop_front();
                    if (want !== out_byte) begin
                        if (fails < 10)
                            $display("out_byte mismatch: expected %02h, got %02h",
                                     want, out_byte);
                        fails <= fails + 1;
                    end
                end
            end
        end
    end

    assign pending = expected_bytes.size();

endmodule

// ----- dv/tb_aes128_ctr_keystream_xor.sv -----
// Testbench top for the AES-128 CTR keystream block: stimulus, idling and verdict.
module tb_aes128_ctr_keystream_xor;
    import actx_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [63:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  data_byte;
    logic        restart;
    logic        out_valid;
    logic        out_stall;
    logic [7:0]  out_byte;
    int          fails;
    int          pending;

    // Idling mode: 0 none, 1 sender idles, 2 receiver stalls, 3 both lightly.
    int          idle_mode;
    int          quiet_cycles;

    aes128_ctr_keystream_xor dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .data_byte(data_byte), .restart(restart),
        .out_valid(out_valid), .out_stall(out_stall), .out_byte(out_byte)
    );

    aes128_ctr_keystream_xor_checker checker_i (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .data_byte(data_byte), .restart(restart),
        .out_valid(out_valid), .out_stall(out_stall), .out_byte(out_byte),
        .fails(fails), .pending(pending)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // The receiver stalls according to the current idling mode. All changes
    // happen on the falling edge so the block samples settled values.
    always @(negedge clk) begin
        case (idle_mode)
            2:       out_stall <= ($urandom_range(99) < 80);
            3:       out_stall <= ($urandom_range(99) < 18);
            default: out_stall <= 1'b0;
        endcase
    end

    // The watchdog counts cycles in which no beat moves on either channel.
    // A slow but correct run never gets close, since an 80 percent stall
    // stretches the time for a block by a small factor only.
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= 20000) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Sends one byte. The sender may sit idle first; once valid is raised
    // the payload holds until the beat is accepted at a rising edge.
    task automatic send_byte(input logic [7:0] value, input logic restart_flag);
        int idle_pct;
        idle_pct = (idle_mode == 1) ? 80 : (idle_mode == 3) ? 18 : 0;
        @(negedge clk);
        while ($urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= value;
        restart   <= restart_flag;
        #1;
        while (in_stall) begin
            @(negedge clk);
            #1;
        end
        @(posedge clk);
    endtask

    // Lets the stream drain so that a register write lands while the block
    // is idle. Every byte yields a result, so no work is left once none is pending.
    task automatic drain;
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (5) @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] index, input logic [63:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Picks a register value, with the extremes showing up often.
    function automatic logic [63:0] pick_value();
        case ($urandom_range(5))
            0:       return '0;
            1:       return '1;
            default: return rand64();
        endcase
    endfunction

    initial begin
        logic [63:0] lo_pick;
        int n;
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = CfgKeyHigh;
        cfg_data  = '0;
        in_valid  = 1'b0;
        data_byte = '0;
        restart   = 1'b0;
        idle_mode = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Straight out of reset without a restart: the counter starts at
        // zero under the all-zero key. A restart in the middle of a block
        // then jumps back to byte position zero.
        send_byte(8'h00, 1'b0);
        send_byte(8'hff, 1'b0);
        for (int i = 0; i < 6; i++) send_byte(8'h55 << (i % 2), 1'b0);
        send_byte(8'haa, 1'b1);
        for (int i = 0; i < 8; i++) send_byte(8'h01 << i, 1'b0);
        drain();

        // All-ones key and counter: the low half wraps and carries, and the
        // high half wraps to zero as well, on the second block.
        write_reg(CfgKeyHigh, '1);
        write_reg(CfgKeyLow, '1);
        write_reg(CfgNonceHigh, '1);
        write_reg(CfgNonceLow, '1);
        send_byte(8'h00, 1'b1);
        for (int i = 0; i < 16; i++) send_byte(8'hff, 1'b0);
        drain();

        // A key change with no restart takes effect at the next block
        // boundary, while the counter just carries on.
        write_reg(CfgKeyLow, 64'h0123456789abcdef);
        for (int i = 0; i < 8; i++) send_byte(8'($urandom_range(255)), 1'b0);

        // Random phases. Each phase rewrites some registers and cycles
        // through the idling modes; most runs are long well-formed streams,
        // with an occasional restart thrown in mid-block.
        for (int phase = 0; phase < 12; phase++) begin
            drain();
            idle_mode = phase % 4;
            for (int r = 0; r < 4; r++) begin
                if ($urandom_range(2) != 0 || phase == 0) begin
                    case (r)
                        0: write_reg(CfgKeyHigh, pick_value());
                        1: write_reg(CfgKeyLow, pick_value());
                        2: write_reg(CfgNonceHigh, pick_value());
                        default:
                        begin
                            lo_pick = pick_value();
                            // Park the counter just below the carry now and then.
                            if ($urandom_range(3) == 0) lo_pick = 64'hffff_ffff_ffff_fffe;
                            write_reg(CfgNonceLow, lo_pick);
                        end
                    endcase
                end
            end
            n = $urandom_range(25, 55);
            for (int i = 0; i < n; i++)
                send_byte(8'($urandom_range(255)),
                          (i == 0) ? ($urandom_range(3) != 0) : ($urandom_range(29) == 0));
        end

        drain();
        repeat (30) @(negedge clk);
        if (fails == 0 && pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ----- aes128_ctr_keystream_xor.f -----
hdl/actx_pkg.sv
hdl/actx_front.sv
hdl/actx_queue.sv
hdl/actx_back.sv
hdl/aes128_ctr_keystream_xor.sv
dv/aes128_ctr_keystream_xor_checker.sv
dv/tb_aes128_ctr_keystream_xor.sv
